>>> rtl/core/differential_drive_pwm_mixer_assert.svh
// Assertion shorthands for the mixer checker.
// Both expect clk and rst_n in scope.
`ifndef DIFFERENTIAL_DRIVE_PWM_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PWM_MIXER_ASSERT_SVH

// Same-cycle implication.
`define DDPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ddpm_pkg.sv
package ddpm_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PWM_PWM_MODE    = 3'd0;
  localparam logic [2:0] CFG_OUTPUTS_ENABLED = 3'd1;
  localparam logic [2:0] CFG_MOTOR_COUNT     = 3'd2;
  localparam logic [2:0] CFG_LEFT_SIDE_MASK  = 3'd3;
  localparam logic [2:0] CFG_REVERSED_MASK   = 3'd4;

  localparam logic [6:0] SPEED_FULL  = 7'd100;
  localparam logic [7:0] BRAKE_DUTY  = 8'd255;
  localparam int unsigned DIV_STEPS  = 7;     // quotient never exceeds 100
  localparam int unsigned RECIP_100  = 5243;  // 2^19 / 100, rounded up
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QADDR_W    = 1;     // command queue of two entries

  typedef struct packed {
    logic              pwm_pwm_mode;
    logic              outputs_enabled;
    logic [3:0]        motor_count;
    logic [7:0]        left_side_mask;
    logic [7:0]        reversed_mask;
  } cfg_t;

  // Mixed command handed from front to back
  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic [7:0]        top;
  } cmd_t;

  // floor(x / 100) for x below 25600, by reciprocal multiply
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP_100);
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

>>> rtl/core/ddpm_front.sv
module ddpm_front
  import ddpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  input  logic               in_scale_to_max,
  input  logic [7:0]         in_speed_limit,
  output logic               push,
  output cmd_t               push_cmd,
  input  logic               q_full
);

  typedef enum logic [1:0] {E_IDLE, E_DIV, E_DONE} eng_state_t;

  eng_state_t  state_r;
  logic [2:0]  step_r;
  logic        hold_vld_r;
  logic [15:0] hold_left_r;
  logic [15:0] hold_right_r;
  logic        hold_scale_r;
  logic [7:0]  hold_limit_r;
  logic [21:0] num_l_r, num_r_r, dvs_r;
  logic [6:0]  ql_r, qr_r;
  logic        neg_l_r, neg_r_r;
  logic [7:0]  top_r;

  logic        eng_load, accept, need_div;
  logic [15:0] mag_l, mag_r, mag_max;
  logic [6:0]  limit_c;
  logic [14:0] limit_x255;
  logic        ge_l, ge_r;

  assign eng_load = (state_r == E_IDLE) && hold_vld_r;
  assign busy     = !rst_n || (hold_vld_r && !eng_load);
  assign accept   = start && !busy;

  // classify the held command
  always_comb begin
    mag_l      = hold_left_r[15]  ? (~hold_left_r + 16'd1)  : hold_left_r;
    mag_r      = hold_right_r[15] ? (~hold_right_r + 16'd1) : hold_right_r;
    mag_max    = (mag_r > mag_l) ? mag_r : mag_l;
    need_div   = ((mag_max > 16'(SPEED_FULL)) || hold_scale_r) && (mag_max != 16'd0);
    limit_c    = (hold_limit_r > 8'(SPEED_FULL)) ? SPEED_FULL : hold_limit_r[6:0];
    limit_x255 = {limit_c, 8'b0} - {8'b0, limit_c};
  end

  assign ge_l = num_l_r >= dvs_r;
  assign ge_r = num_r_r >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= E_IDLE;
      step_r     <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        hold_vld_r <= 1'b1;
      end else if (eng_load) begin
        hold_vld_r <= 1'b0;
      end
      unique case (state_r)
        E_IDLE: begin
          if (hold_vld_r) begin
            state_r <= need_div ? E_DIV : E_DONE;
            step_r  <= 3'(DIV_STEPS - 1);
          end
        end
        E_DIV: begin
          step_r <= step_r - 3'd1;
          if (step_r == 3'd0) state_r <= E_DONE;
        end
        E_DONE: begin
          if (push) state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  // payload: hold register and restoring divider
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_left_r  <= in_left_speed;
      hold_right_r <= in_right_speed;
      hold_scale_r <= in_scale_to_max;
      hold_limit_r <= in_speed_limit;
    end
    if (eng_load) begin
      num_l_r <= 22'(mag_l) * 22'(SPEED_FULL);
      num_r_r <= 22'(mag_r) * 22'(SPEED_FULL);
      dvs_r   <= {mag_max[15:0], 6'b0};
      ql_r    <= mag_l[6:0];
      qr_r    <= mag_r[6:0];
      neg_l_r <= hold_left_r[15];
      neg_r_r <= hold_right_r[15];
      top_r   <= div100(limit_x255);
    end else if (state_r == E_DIV) begin
      if (ge_l) num_l_r <= num_l_r - dvs_r;
      if (ge_r) num_r_r <= num_r_r - dvs_r;
      ql_r  <= {ql_r[5:0], ge_l};
      qr_r  <= {qr_r[5:0], ge_r};
      dvs_r <= dvs_r >> 1;
    end
  end

  assign push           = (state_r == E_DONE) && !q_full;
  assign push_cmd.left  = neg_l_r ? (8'd0 - {1'b0, ql_r}) : {1'b0, ql_r};
  assign push_cmd.right = neg_r_r ? (8'd0 - {1'b0, qr_r}) : {1'b0, qr_r};
  assign push_cmd.top   = top_r;

endmodule

>>> rtl/core/ddpm_queue.sv
module ddpm_queue
  import ddpm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int unsigned QDEPTH = 1 << QADDR_W;

  cmd_t               mem_r [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QADDR_W:0]   cnt_r;

  assign full    = cnt_r == (QADDR_W + 1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

>>> rtl/core/ddpm_back.sv
module ddpm_back
  import ddpm_pkg::*;
#(
  parameter int MOTOR_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              pop,
  output logic              out_valid,
  output logic [2:0]        out_motor_index,
  output logic [7:0]        out_duty_a,
  output logic [7:0]        out_duty_b,
  output logic signed [7:0] out_applied_speed,
  output logic              out_drive_active,
  output logic              out_last_motor
);

  logic              busy_r;
  logic [2:0]        idx_r;
  cmd_t              cmd_r;
  logic              p1_vld_r, p1_last_r;
  logic [2:0]        p1_idx_r;
  logic signed [7:0] p1_s_r;
  logic [14:0]       p1_prod_r;

  logic [3:0]        cnt_sat;
  logic              last_issue;
  logic signed [7:0] s_sel, s_dir, s_neg;
  logic [6:0]        mag_s;
  logic [7:0]        duty, a_nxt, b_nxt;

  assign cnt_sat    = (cfg.motor_count > 4'(MOTOR_SLOTS)) ? 4'(MOTOR_SLOTS)
                                                          : cfg.motor_count;
  assign last_issue = busy_r && (({1'b0, idx_r} + 4'd1) == cnt_sat);
  assign pop        = !q_empty && (!busy_r || last_issue);

  // side select and reversal; mixed speeds already lie within +-100
  always_comb begin
    s_sel = cfg.left_side_mask[idx_r] ? cmd_r.left : cmd_r.right;
    s_dir = cfg.reversed_mask[idx_r] ? (8'sd0 - s_sel) : s_sel;
    s_neg = 8'sd0 - s_dir;
    mag_s = s_dir[7] ? s_neg[6:0] : s_dir[6:0];
  end

  always_comb begin
    duty = div100(p1_prod_r);
    if (p1_s_r == 8'sd0) begin
      a_nxt = cfg.pwm_pwm_mode ? BRAKE_DUTY : 8'd0;
      b_nxt = a_nxt;
    end else if (!p1_s_r[7]) begin
      a_nxt = duty;
      b_nxt = 8'd0;
    end else if (cfg.pwm_pwm_mode) begin
      a_nxt = 8'd0;
      b_nxt = duty;
    end else begin
      a_nxt = duty;
      b_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idx_r     <= '0;
      p1_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= cnt_sat != 4'd0;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 3'd1;
        if (last_issue) busy_r <= 1'b0;
      end
      p1_vld_r  <= busy_r;
      out_valid <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_cmd;
    p1_idx_r          <= idx_r;
    p1_last_r         <= last_issue;
    p1_s_r            <= s_dir;
    p1_prod_r         <= 15'(mag_s) * 15'(cmd_r.top);
    out_motor_index   <= p1_idx_r;
    out_duty_a        <= a_nxt;
    out_duty_b        <= b_nxt;
    out_applied_speed <= p1_s_r;
    out_drive_active  <= cfg.outputs_enabled;
    out_last_motor    <= p1_last_r;
  end

endmodule

>>> rtl/core/differential_drive_pwm_mixer.sv
// A taken command passes the hold register, the front engine (its 7-step restoring divider
// runs only when scaling applies, one quotient bit per cycle), the queue and the back end.
// Throughput: one result beat per cycle per motor while commands are queued; the front
// takes one while still on the last, so the slower of motor count and divider sets pace.
// Reset: synchronous, active-low rst_n clears control and restores config defaults.
// The receiver cannot stall: each result beat shows on out_valid for one cycle.
module differential_drive_pwm_mixer
  import ddpm_pkg::*;
#(
  parameter int MOTOR_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  input  logic               in_scale_to_max,
  input  logic [7:0]         in_speed_limit,
  // result channel
  output logic               out_valid,
  output logic [2:0]         out_motor_index,
  output logic [7:0]         out_duty_a,
  output logic [7:0]         out_duty_b,
  output logic signed [7:0]  out_applied_speed,
  output logic               out_drive_active,
  output logic               out_last_motor,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  cfg_t cfg_r;
  logic push, q_full, q_empty, pop;
  cmd_t push_cmd, pop_cmd;

  // Config writes take effect in the cycle after they are taken; never hold off the writer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_pwm_mode    <= 1'b1;
      cfg_r.outputs_enabled <= 1'b1;
      cfg_r.motor_count     <= '0;
      cfg_r.left_side_mask  <= '0;
      cfg_r.reversed_mask   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PWM_PWM_MODE:    cfg_r.pwm_pwm_mode    <= cfg_data[0];
        CFG_OUTPUTS_ENABLED: cfg_r.outputs_enabled <= cfg_data[0];
        CFG_MOTOR_COUNT:     cfg_r.motor_count     <= cfg_data[3:0];
        CFG_LEFT_SIDE_MASK:  cfg_r.left_side_mask  <= cfg_data;
        CFG_REVERSED_MASK:   cfg_r.reversed_mask   <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Front: hold one command, mix (scale to the larger magnitude when needed),
  // compute the limit-derived top duty, then hand the command to the queue.
  ddpm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_left_speed   (in_left_speed),
    .in_right_speed  (in_right_speed),
    .in_scale_to_max (in_scale_to_max),
    .in_speed_limit  (in_speed_limit),
    .push            (push),
    .push_cmd        (push_cmd),
    .q_full          (q_full)
  );

  // Two-entry queue decouples the divider from the per-motor sequencer.
  ddpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back: walk the motors one per cycle through a two-stage duty pipeline.
  ddpm_back #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_cmd             (pop_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_motor_index   (out_motor_index),
    .out_duty_a        (out_duty_a),
    .out_duty_b        (out_duty_b),
    .out_applied_speed (out_applied_speed),
    .out_drive_active  (out_drive_active),
    .out_last_motor    (out_last_motor)
  );

endmodule

>>> rtl/core/ddpm_checker.sv
`include "differential_drive_pwm_mixer_assert.svh"

module ddpm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic [2:0]        out_motor_index,
  input logic [7:0]        out_duty_a,
  input logic [7:0]        out_duty_b,
  input logic signed [7:0] out_applied_speed,
  input logic              out_last_motor
);

  // Applied speed stays within full scale.
  `DDPM_ASSERT_IMP(a_speed_range, out_valid, (out_applied_speed <= 8'sd100) && (out_applied_speed >= -8'sd100), "applied speed out of range")

  // Zero speed sets both outputs alike, to 255 or to 0.
  `DDPM_ASSERT_IMP(a_brake, out_valid && (out_applied_speed == 8'sd0), (out_duty_a == out_duty_b) && ((out_duty_a == 8'd255) || (out_duty_a == 8'd0)), "brake duties mismatch")

  // Forward speed never drives the second output.
  `DDPM_ASSERT_IMP(a_forward, out_valid && (out_applied_speed > 8'sd0), out_duty_b == 8'd0, "forward drives output b")

  // Beats of one command come back to back in motor order.
  `DDPM_ASSERT_NXT(a_motor_seq, out_valid && !out_last_motor, out_valid && (out_motor_index == 3'($past(out_motor_index) + 3'd1)), "motor sequence broken")

endmodule

bind differential_drive_pwm_mixer ddpm_checker u_ddpm_checker (.*);

>>> test/tb_differential_drive_pwm_mixer.sv
`timescale 1ns / 1ps

module tb_differential_drive_pwm_mixer;
  import ddpm_pkg::*;

  localparam int MOTOR_SLOTS = 8;
  // Hold off this many cycles once the last drive beat is in: commands that
  // produce no beats (no motors) may still sit in the block's front end.
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [2:0] CFG_SPARE_LO = CFG_REVERSED_MASK + 3'd1;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  // One drive beat as the block presents it.
  typedef struct packed {
    logic [2:0]        motor_index;
    logic [7:0]        duty_a;
    logic [7:0]        duty_b;
    logic signed [7:0] applied_speed;
    logic              drive_active;
    logic              last_motor;
  } motor_drive_t;

  // Mixer model: a shadow of the registers, the drive beats still owed by the
  // block, and the compare of each beat that comes out.
  class drive_mixer_model;
    logic         pwm_mode;
    logic         enabled;
    logic [3:0]   motor_count;
    logic [7:0]   left_mask;
    logic [7:0]   rev_mask;
    motor_drive_t pending_drives[$];
    int unsigned  mismatches;

    function new();
      pwm_mode    = 1'b1;
      enabled     = 1'b1;
      motor_count = 4'd0;
      left_mask   = 8'd0;
      rev_mask    = 8'd0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        CFG_PWM_PWM_MODE:    pwm_mode    = data[0];
        CFG_OUTPUTS_ENABLED: enabled     = data[0];
        CFG_MOTOR_COUNT:     motor_count = data[3:0];
        CFG_LEFT_SIDE_MASK:  left_mask   = data;
        CFG_REVERSED_MASK:   rev_mask    = data;
        default: ;
      endcase
    endfunction

    // Mix one command and queue one drive beat per attached motor.
    function void take_command(logic signed [15:0] l_in, logic signed [15:0] r_in,
                               logic scale, logic [7:0] limit);
      int lspd, rspd, peak, lim, top, n, s, mag, duty;
      motor_drive_t d;
      lspd = l_in;
      rspd = r_in;
      peak = (lspd < 0) ? -lspd : lspd;
      if (((rspd < 0) ? -rspd : rspd) > peak) peak = (rspd < 0) ? -rspd : rspd;
      // signed int division truncates toward zero, as the scaling wants
      if ((peak > 100 || scale) && peak != 0) begin
        lspd = (lspd * 100) / peak;
        rspd = (rspd * 100) / peak;
      end
      lim = (limit > 100) ? 100 : limit;
      top = (lim * 255) / 100;
      n = (motor_count > MOTOR_SLOTS) ? MOTOR_SLOTS : motor_count;
      for (int i = 0; i < n; i++) begin
        s = left_mask[i] ? lspd : rspd;
        if (rev_mask[i]) s = -s;
        if (s > 100) s = 100;
        if (s < -100) s = -100;
        mag = (s < 0) ? -s : s;
        duty = (mag * top) / 100;
        if (s == 0) begin
          d.duty_a = pwm_mode ? BRAKE_DUTY : 8'd0;
          d.duty_b = d.duty_a;
        end else if (s > 0) begin
          d.duty_a = 8'(duty);
          d.duty_b = 8'd0;
        end else if (pwm_mode) begin
          d.duty_a = 8'd0;
          d.duty_b = 8'(duty);
        end else begin
          d.duty_a = 8'(duty);
          d.duty_b = 8'd1;
        end
        d.motor_index   = 3'(i);
        d.applied_speed = 8'(s);
        d.drive_active  = enabled;
        d.last_motor    = (i + 1 == n);
        pending_drives.push_back(d);
      end
    endfunction

    function void flag(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_drive(motor_drive_t got);
      motor_drive_t want;
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected drive beat, expected none, actual motor %0d",
                 $time, got.motor_index);
        mismatches++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.motor_index !== want.motor_index)
        flag("motor_index", want.motor_index, got.motor_index);
      if (got.duty_a !== want.duty_a) flag("duty_a", want.duty_a, got.duty_a);
      if (got.duty_b !== want.duty_b) flag("duty_b", want.duty_b, got.duty_b);
      if (got.applied_speed !== want.applied_speed)
        flag("applied_speed", want.applied_speed, got.applied_speed);
      if (got.drive_active !== want.drive_active)
        flag("drive_active", want.drive_active, got.drive_active);
      if (got.last_motor !== want.last_motor)
        flag("last_motor", want.last_motor, got.last_motor);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_left_speed = '0;
  logic signed [15:0] in_right_speed = '0;
  logic               in_scale_to_max = 1'b0;
  logic [7:0]         in_speed_limit = '0;
  logic               out_valid;
  logic [2:0]         out_motor_index;
  logic [7:0]         out_duty_a;
  logic [7:0]         out_duty_b;
  logic signed [7:0]  out_applied_speed;
  logic               out_drive_active;
  logic               out_last_motor;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  drive_mixer_model mixer = new();
  bit               quiet = 1'b0;  // set to suppress sender idling
  int unsigned      cycles = 0;

  differential_drive_pwm_mixer #(
    .MOTOR_SLOTS(MOTOR_SLOTS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_left_speed     (in_left_speed),
    .in_right_speed    (in_right_speed),
    .in_scale_to_max   (in_scale_to_max),
    .in_speed_limit    (in_speed_limit),
    .out_valid         (out_valid),
    .out_motor_index   (out_motor_index),
    .out_duty_a        (out_duty_a),
    .out_duty_b        (out_duty_b),
    .out_applied_speed (out_applied_speed),
    .out_drive_active  (out_drive_active),
    .out_last_motor    (out_last_motor),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort on a hang: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Capture every drive beat at the edge that ends its strobe cycle; the
  // block cannot be stalled, so no ready goes back.
  always @(posedge clk) begin : drive_monitor
    motor_drive_t got;
    if (rst_n && out_valid) begin
      got.motor_index   = out_motor_index;
      got.duty_a        = out_duty_a;
      got.duty_b        = out_duty_b;
      got.applied_speed = out_applied_speed;
      got.drive_active  = out_drive_active;
      got.last_motor    = out_last_motor;
      mixer.check_drive(got);
    end
  end

  // Write one register; hold valid until ready, then drop it for a cycle.
  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    mixer.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic mode, input logic en, input logic [3:0] count,
                           input logic [7:0] lmask, input logic [7:0] rmask);
    // Random upper bits on the narrow registers: only the low bits may count.
    cfg_write(CFG_PWM_PWM_MODE, {7'($urandom), mode});
    cfg_write(CFG_OUTPUTS_ENABLED, {7'($urandom), en});
    cfg_write(CFG_MOTOR_COUNT, {4'($urandom), count});
    cfg_write(CFG_LEFT_SIDE_MASK, lmask);
    cfg_write(CFG_REVERSED_MASK, rmask);
  endtask

  // Present one command beat and hold it until the block takes it. Start is
  // left high so a back-to-back command follows without a bubble.
  task automatic send_cmd(input logic signed [15:0] l, input logic signed [15:0] r,
                          input logic scale, input logic [7:0] limit);
    if (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start           <= 1'b1;
    in_left_speed   <= l;
    in_right_speed  <= r;
    in_scale_to_max <= scale;
    in_speed_limit  <= limit;
    do @(posedge clk); while (busy);
    mixer.take_command(l, r, scale, limit);
  endtask

  // Stop sending, wait for every owed beat, then let the front end drain.
  task automatic settle();
    start <= 1'b0;
    while (mixer.pending_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Brake, full scale both ways, 16-bit extremes, limits at and past 100,
  // scaling with a zero peak, and speeds just over 100.
  task automatic run_directed();
    send_cmd(16'sd0, 16'sd0, 1'b0, 8'd100);
    send_cmd(16'sd100, -16'sd100, 1'b0, 8'd100);
    send_cmd(16'sd32767, -16'sd32768, 1'b0, 8'd255);
    send_cmd(-16'sd32768, 16'sd32767, 1'b1, 8'd0);
    send_cmd(16'sd50, -16'sd25, 1'b1, 8'd100);
    send_cmd(16'sd0, 16'sd0, 1'b1, 8'd50);
    send_cmd(16'sd1, -16'sd1, 1'b0, 8'd1);
    send_cmd(16'sd101, 16'sd50, 1'b0, 8'd101);
    send_cmd(-16'sd1, 16'sd0, 1'b1, 8'd99);
    send_cmd(-16'sd77, 16'sd33, 1'b0, 8'd73);
  endtask

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(9))
      0, 1, 2, 3: rand_speed = 16'($urandom_range(240) - 120);
      4, 5, 6:    rand_speed = 16'($urandom);
      7: begin
        case ($urandom_range(5))
          0: rand_speed = 16'sd32767;
          1: rand_speed = -16'sd32768;
          2: rand_speed = 16'sd100;
          3: rand_speed = -16'sd100;
          4: rand_speed = 16'sd101;
          default: rand_speed = 16'sd0;
        endcase
      end
      default: rand_speed = 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  initial begin
    // Hold reset low from the start, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No motors out of reset: commands are taken but give no beats.
    send_cmd(16'sd40, -16'sd40, 1'b0, 8'd100);
    send_cmd(16'sd200, 16'sd10, 1'b1, 8'd255);
    settle();

    // PWM/PWM with all slots; spare indexes must leave the registers alone.
    write_all(1'b1, 1'b1, 4'd8, 8'h0F, 8'hA5);
    cfg_write(CFG_SPARE_LO, 8'hFF);
    cfg_write(CFG_SPARE_HI, 8'h00);
    run_directed();
    settle();

    // Phase/enable, outputs off, a motor count past the slots.
    write_all(1'b0, 1'b0, 4'd15, 8'h33, 8'h0F);
    run_directed();
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_all(1'b1, 1'b1, 4'd8, 8'hFF, 8'h00);
        1: write_all(1'b0, 1'b1, 4'd8, 8'h00, 8'hFF);
        2: write_all(1'($urandom), 1'($urandom), 4'd1, 8'($urandom), 8'($urandom));
        default: write_all(1'($urandom), 1'($urandom), 4'($urandom_range(1, 15)),
                           8'($urandom), 8'($urandom));
      endcase
      // Run one phase at full rate with no idling at all.
      quiet = (ph == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Pause mid-phase until the block has delivered everything.
        if (k == ITEMS_PER_PHASE / 2) settle();
        send_cmd(rand_speed(), rand_speed(), 1'($urandom_range(2) == 0),
                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100)));
      end
      settle();
    end

    if (mixer.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ddpm_pkg.sv
rtl/core/ddpm_front.sv
rtl/core/ddpm_queue.sv
rtl/core/ddpm_back.sv
rtl/core/differential_drive_pwm_mixer.sv
rtl/core/ddpm_checker.sv
test/tb_differential_drive_pwm_mixer.sv
